@@ sv/assert_macros.svh @@
// Assertion helpers shared by the point-in-polygon RTL.
// Each helper expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PIP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Types, codes and default sizes for the point-in-polygon test unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int MIN_VERTICES     = 3;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  // Request word
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pip_in_t;

  // Response word
  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
    logic [6:0] vertex_count;
  } pip_out_t;

endpackage

@@ sv/pip_vtx_mem.sv @@
// ----------------------------------------------------------------------------
// pip_vtx_mem
// Vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_vtx_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pip_div.sv @@
// ----------------------------------------------------------------------------
// pip_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_div #(
  parameter int CW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*CW-1:0] num,
  input  logic [CW-1:0]   den,
  output logic            done,
  output logic [2*CW-1:0] quo
);

  localparam int NB  = 2 * CW;
  localparam int DCW = $clog2(NB);

  logic [CW-1:0]  rem;
  logic [DCW-1:0] step;
  logic           busy;
  logic [CW:0]    trial;
  logic [CW:0]    diff;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem, quo[NB-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == DCW'(NB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (!diff[CW]) begin
        rem <= diff[CW-1:0];
        quo <= {quo[NB-2:0], 1'b1};
      end else begin
        rem <= trial[CW-1:0];
        quo <= {quo[NB-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/point_in_polygon_test_unit.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Vertex table with duplicate check and an even-odd crossing point test.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  req     | in        | req_valid/req_ready  | pip_in_t (kind, x, y)
//  rsp     | out       | rsp_valid/rsp_ready  | pip_out_t (inside_res, status, count)
//
// One item at a time; a clear, unused kind or short query goes straight to the answer.
// An add to a non-empty table scans it through the memory read port for a duplicate.
// A query reads the vertices in turn, then answers; each edge crossing the query
// row adds a multiply, then a division in the divider.
// Reset clears the vertex count and handshake state; the table is not cleared.
// A response waiting on rsp_ready does not stop the next request being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pip_pkg::pip_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output pip_pkg::pip_out_t rsp
);

  import pip_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DUP  = 3'd1;
  localparam logic [2:0] S_QISS = 3'd2;
  localparam logic [2:0] S_QEVL = 3'd3;
  localparam logic [2:0] S_QMUL = 3'd4;
  localparam logic [2:0] S_QDST = 3'd5;
  localparam logic [2:0] S_QDWT = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [1:0]            kind;
  logic signed [CW-1:0]  px, py;
  logic                  dup;
  logic                  parity;
  logic [CNT_W-1:0]      iss;
  logic                  rv, rlast;
  logic [CNT_W-1:0]      qcnt;
  logic signed [CW-1:0]  xj, yj, xe;
  logic [CW-1:0]         am, bm, dm;
  logic                  neg;
  logic [2*CW-1:0]       prod;

  logic                  acc;
  logic signed [31:0]    wx, wy;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [2*CW-1:0]       mem_rdata;
  logic [CNT_W-1:0]      cnt_m1, q_addr;
  logic                  dup_iss;
  logic signed [CW-1:0]  xi, yi;
  logic signed [CW:0]    a_d, b_d, d_d, a_m, b_m, d_m;
  logic                  straddle;
  logic                  div_done;
  logic [2*CW-1:0]       quo;
  logic signed [2*CW:0]  q_s;
  logic signed [2*CW+1:0] sum, px_ext;
  logic                  fire;
  logic                  full;
  logic                  q_last;

  assign acc       = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign wx        = 32'(req.x);
  assign wy        = 32'(req.y);

  // Table addressing
  assign cnt_m1   = cnt - 1'b1;
  assign q_addr   = (qcnt == '0) ? cnt_m1 : qcnt - 1'b1;
  assign q_last   = (qcnt == cnt);
  assign dup_iss  = (state == S_DUP) && (iss < cnt);
  assign mem_re   = dup_iss || (state == S_QISS);
  assign mem_raddr = (state == S_DUP) ? iss[IDX_W-1:0] : q_addr[IDX_W-1:0];
  assign full     = (cnt >= CNT_W'(MAX_VERTICES));
  assign fire     = (state == S_FIN) && (!rsp_valid || rsp_ready);
  assign mem_we   = fire && (kind == KIND_ADD) && !dup && !full;

  pip_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (IDX_W),
    .DW    (2 * CW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata ({px, py}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Edge terms from the vertex just read
  assign xi       = mem_rdata[2*CW-1:CW];
  assign yi       = mem_rdata[CW-1:0];
  assign straddle = (yi > py) != (yj > py);
  assign a_d      = {xj[CW-1], xj} - {xi[CW-1], xi};
  assign b_d      = {py[CW-1], py} - {yi[CW-1], yi};
  assign d_d      = {yj[CW-1], yj} - {yi[CW-1], yi};
  assign a_m      = a_d[CW] ? -a_d : a_d;
  assign b_m      = b_d[CW] ? -b_d : b_d;
  assign d_m      = d_d[CW] ? -d_d : d_d;

  pip_div #(
    .CW (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_QDST),
    .num   (prod),
    .den   (dm),
    .done  (div_done),
    .quo   (quo)
  );

  // Crossing x relative to the query point
  assign q_s    = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum    = {q_s[2*CW], q_s} + {{(CW+2){xe[CW-1]}}, xe};
  assign px_ext = {{(CW+2){px[CW-1]}}, px};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rv        <= 1'b0;
      rlast     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rv    <= dup_iss;
      rlast <= dup_iss && (iss == cnt_m1);
      // Response valid: raised on a finished item, dropped once taken
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req.kind == KIND_ADD && cnt != '0) begin
              state <= S_DUP;
            end else if (req.kind == KIND_QUERY && cnt >= CNT_W'(MIN_VERTICES)) begin
              state <= S_QISS;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DUP: begin
          if (rv && rlast) begin
            state <= S_FIN;
          end
        end
        S_QISS: state <= S_QEVL;
        S_QEVL: begin
          if (qcnt != '0 && straddle) begin
            state <= S_QMUL;
          end else if (q_last) begin
            state <= S_FIN;
          end else begin
            state <= S_QISS;
          end
        end
        S_QMUL: state <= S_QDST;
        S_QDST: state <= S_QDWT;
        S_QDWT: begin
          if (div_done) begin
            state <= q_last ? S_FIN : S_QISS;
          end
        end
        S_FIN: begin
          if (fire) begin
            state <= S_IDLE;
            if (kind == KIND_CLEAR) begin
              cnt <= '0;
            end else if (mem_we) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (acc) begin
      kind   <= req.kind;
      px     <= wx[CW-1:0];
      py     <= wy[CW-1:0];
      dup    <= 1'b0;
      parity <= 1'b0;
      iss    <= '0;
      qcnt   <= '0;
    end
    if (dup_iss) begin
      iss <= iss + 1'b1;
    end
    if (state == S_DUP && rv && xi == px && yi == py) begin
      dup <= 1'b1;
    end
    if (state == S_QEVL) begin
      xj <= xi;
      yj <= yi;
      xe <= xi;
      am <= a_m[CW-1:0];
      bm <= b_m[CW-1:0];
      dm <= d_m[CW-1:0];
      neg <= a_d[CW] ^ b_d[CW] ^ d_d[CW];
      if (!(qcnt != '0 && straddle) && !q_last) begin
        qcnt <= qcnt + 1'b1;
      end
    end
    if (state == S_QMUL) begin
      prod <= am * bm;
    end
    if (state == S_QDWT && div_done) begin
      if (px_ext < sum) begin
        parity <= !parity;
      end
      if (!q_last) begin
        qcnt <= qcnt + 1'b1;
      end
    end
    if (fire) begin
      rsp.inside_res   <= (kind == KIND_QUERY) && (cnt >= CNT_W'(MIN_VERTICES)) && parity;
      rsp.vertex_count <= (kind == KIND_CLEAR) ? 7'd0 : (mem_we ? 7'(cnt + 1'b1) : 7'(cnt));
      case (kind)
        KIND_ADD:   rsp.status <= dup ? ST_DUP : (full ? ST_FULL : ST_OK);
        KIND_QUERY: rsp.status <= (cnt < CNT_W'(MIN_VERTICES)) ? ST_SHORT : ST_OK;
        default:    rsp.status <= ST_OK;
      endcase
    end
  end

  // Checks
  `PIP_ASSERT(a_cnt_range, cnt <= CNT_W'(MAX_VERTICES), "vertex count beyond table size")
  `PIP_NEVER(a_wr_full, mem_we && full, "write into a full table")
  `PIP_ASSERT(a_div_state, div_done |-> state == S_QDWT, "divider result outside wait state")
  `PIP_ASSERT(a_short_q, (acc && req.kind == KIND_QUERY && cnt < CNT_W'(MIN_VERTICES)) |=> state == S_FIN, "short query did not skip scan")

endmodule

@@ tb/sv/tb_point_in_polygon_test_unit.sv @@
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_unit
// Drives clear, add and query words into the point-in-polygon unit and
// checks every response against an in-bench model of the vertex table and
// the even-odd crossing test, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_in_polygon_test_unit;
  import pip_pkg::*;

  localparam int NVERT = MAX_VERTICES_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  pip_in_t  req;
  logic     rsp_valid;
  logic     rsp_ready;
  pip_out_t rsp;

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_queries = 0;
  int n_inside = 0;
  int n_dup = 0;
  int n_full = 0;

  point_in_polygon_test_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Polygon table model and queue of expected response words
  class polygon_scoreboard;
    longint xs[NVERT];
    longint ys[NVERT];
    int     count;
    pip_out_t pending[$];

    function longint crossing_quot(longint a, longint b, longint d);
      longint q;
      q = (a * b) / d;  // SV division truncates toward zero
      return q;
    endfunction

    function bit point_inside(longint px, longint py);
      bit in;
      int j;
      longint q;
      in = 0;
      j = count - 1;
      for (int i = 0; i < count; i++) begin
        if ((ys[i] > py) != (ys[j] > py)) begin
          q = crossing_quot(xs[j] - xs[i], py - ys[i], ys[j] - ys[i]);
          if (px < q + xs[i]) in = !in;
        end
        j = i;
      end
      return in;
    endfunction

    function void note_word(pip_in_t w);
      pip_out_t r;
      longint px, py;
      bit dup;
      px = w.x;
      py = w.y;
      r = '0;
      case (w.kind)
        KIND_CLEAR: count = 0;
        KIND_ADD: begin
          dup = 0;
          for (int k = 0; k < count; k++)
            if (xs[k] == px && ys[k] == py) dup = 1;
          if (dup) begin
            r.status = ST_DUP;
            n_dup++;
          end else if (count >= NVERT) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            xs[count] = px;
            ys[count] = py;
            count++;
          end
        end
        KIND_QUERY: begin
          n_queries++;
          if (count < MIN_VERTICES) r.status = ST_SHORT;
          else r.inside_res = point_inside(px, py);
          if (r.inside_res) n_inside++;
        end
        default: ;
      endcase
      r.vertex_count = 7'(count);
      pending = {pending, r};
    endfunction

    task check_word(pip_out_t got);
      pip_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected response word", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.inside_res !== want.inside_res)
        report_mismatch("inside_res", got.inside_res, want.inside_res);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.vertex_count !== want.vertex_count)
        report_mismatch("vertex_count", got.vertex_count, want.vertex_count);
    endtask
  endclass

  polygon_scoreboard sb = new();

  initial begin
    clk = 0;
  end
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Response side: random stall, check on acceptance
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_word(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d words outstanding", sb.pending.size());
        $display("tb_point_in_polygon_test_unit NOT OK");
        $finish;
      end
    end
  end

  // Valid stays up between back-to-back words; it drops only for idling and in drain
  task automatic send_word(input logic [1:0] kind, input logic [15:0] x,
                           input logic [15:0] y);
    pip_in_t w;
    w.kind = kind;
    w.x = x;
    w.y = y;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_word(w);
    n_sent++;
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Random polygon with coordinates within span, then queries around it
  task automatic random_polygon(input int span);
    int nv;
    int nq;
    send_word(KIND_CLEAR, 16'($urandom), 16'($urandom));
    nv = ($urandom_range(9) == 0) ? $urandom_range(NVERT + 3, 3)
                                  : $urandom_range(8, 3);
    nq = $urandom_range(10, 4);
    for (int k = 0; k < nv; k++)
      send_word(KIND_ADD, 16'($signed($urandom_range(2 * span)) - span),
                16'($signed($urandom_range(2 * span)) - span));
    for (int k = 0; k < nq; k++)
      send_word(KIND_QUERY, 16'($signed($urandom_range(2 * span + 4)) - span - 2),
                16'($signed($urandom_range(2 * span + 4)) - span - 2));
  endtask

  task automatic random_phase(input int n_items);
    int start;
    start = n_sent;
    while (n_sent - start < n_items) begin
      if ($urandom_range(9) < 8) begin
        random_polygon(($urandom_range(3) == 0) ? 32767 : 20);
      end else begin
        // noise: any kind with full-range coordinates
        send_word(2'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short queries, extreme square, duplicate, unused kind
    send_word(KIND_QUERY, 16'sd0, 16'sd0);
    send_word(KIND_ADD, 16'h8000, 16'h8000);
    send_word(KIND_ADD, 16'h8000, 16'h8000);
    send_word(KIND_QUERY, 16'sd0, 16'sd0);
    send_word(KIND_ADD, 16'h7fff, 16'h8000);
    send_word(KIND_ADD, 16'h7fff, 16'h7fff);
    send_word(KIND_ADD, 16'h8000, 16'h7fff);
    send_word(KIND_QUERY, 16'sd0, 16'sd0);
    send_word(KIND_QUERY, 16'h7fff, 16'h7fff);
    send_word(KIND_QUERY, 16'h8000, 16'h8000);
    send_word(KIND_QUERY, 16'h7ffe, 16'h8001);
    send_word(2'd3, 16'hffff, 16'hffff);
    send_word(KIND_CLEAR, 16'sd0, 16'sd0);
    // Fill the table, then a duplicate while full, then a fresh one
    for (int k = 0; k < NVERT; k++) send_word(KIND_ADD, 16'(k), 16'(k * k));
    send_word(KIND_ADD, 16'sd3, 16'sd9);
    send_word(KIND_ADD, 16'sd5, 16'sd1);
    send_word(KIND_QUERY, 16'sd2, 16'sd5);
    // Every expected word in before carrying on
    drain();

    send_idle_pct = 32;
    recv_idle_pct = 74;
    random_phase(270);
    send_idle_pct = 74;
    recv_idle_pct = 32;
    random_phase(270);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(270);

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d words, %0d queries (%0d inside), %0d duplicate and %0d full rejections",
             n_sent, n_queries, n_inside, n_dup, n_full);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_point_in_polygon_test_unit OK");
    end else begin
      $display("tb_point_in_polygon_test_unit NOT OK");
    end
    $finish;
  end

endmodule
